FILE: hdl/csi_pkg.sv
`timescale 1ns / 1ps

package csi_pkg;

  // width of a collected parameter value
  localparam int VALUE_BITS = 16;
  localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

  // byte codes that steer the parser
  localparam logic [7:0] BYTE_ESC    = 8'h1B;
  localparam logic [7:0] BYTE_LBRACK = 8'h5B;
  localparam logic [7:0] BYTE_SEMI   = 8'h3B;
  localparam logic [7:0] BYTE_ZERO   = 8'h30;
  localparam logic [7:0] BYTE_NINE   = 8'h39;
  localparam logic [7:0] BYTE_UP_A   = 8'h41;
  localparam logic [7:0] BYTE_UP_Z   = 8'h5A;
  localparam logic [7:0] BYTE_LO_A   = 8'h61;
  localparam logic [7:0] BYTE_LO_Z   = 8'h7A;
  localparam logic [7:0] BYTE_FIN_J  = 8'h4A;
  localparam logic [7:0] BYTE_FIN_K  = 8'h4B;
  localparam logic [7:0] BYTE_FIN_H  = 8'h48;
  localparam logic [7:0] BYTE_FIN_M  = 8'h6D;

  // colour parameter ranges
  localparam logic [VALUE_BITS-1:0] FORE_LO = VALUE_BITS'(30);
  localparam logic [VALUE_BITS-1:0] FORE_HI = VALUE_BITS'(37);
  localparam logic [VALUE_BITS-1:0] BACK_LO = VALUE_BITS'(40);
  localparam logic [VALUE_BITS-1:0] BACK_HI = VALUE_BITS'(47);
  localparam logic [VALUE_BITS-1:0] ERASE_ALL = VALUE_BITS'(2);

  localparam logic [2:0] COLOUR_WHITE = 3'd7;
  localparam logic [2:0] COLOUR_BLACK = 3'd0;

  // parameter count saturates here
  localparam logic [1:0] COUNT_MAX = 2'd3;
  localparam logic [1:0] COUNT_TWO = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ESC     = 2'd1,
    MODE_CSI     = 2'd2,
    MODE_SWALLOW = 2'd3
  } parse_mode_t;

  typedef enum logic [2:0] {
    KIND_PRINT      = 3'd0,
    KIND_CLEAR_ALL  = 3'd1,
    KIND_CLEAR_DOWN = 3'd2,
    KIND_CLEAR_EOL  = 3'd3,
    KIND_CURSOR     = 3'd4,
    KIND_COLOUR     = 3'd5
  } kind_t;

  // a colour waiting for the 'm' final
  typedef struct packed {
    logic       pend;
    logic [2:0] idx;
  } colour_pend_t;

endpackage

FILE: hdl/csi_if.sv
`timescale 1ns / 1ps

// byte channel into the parser
interface csi_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// command channel out of the parser
interface csi_out_if
  import csi_pkg::*;
  ;
  logic       valid;
  logic       ready;
  kind_t      kind;
  logic [7:0] print_byte;
  logic [15:0] row;
  logic [15:0] column;
  logic [2:0] fore_index;
  logic [2:0] back_index;

  modport source (output valid, output kind, output print_byte, output row, output column,
                  output fore_index, output back_index, input ready);
  modport sink   (input valid, input kind, input print_byte, input row, input column,
                  input fore_index, input back_index, output ready);
endinterface

FILE: hdl/ansi_csi_escape_parser_top.sv
`timescale 1ns / 1ps

// Terminal escape parser: one byte enters per clock and at most one display command
// leaves per byte, passing through the input register and then the result
// register. Plain bytes come out as print commands; ESC [ sequences with ';'-separated
// decimal parameters ending in J, K, H or m come out as clear, cursor-move or colour
// commands when the final accepts their parameters; every other escape is dropped.
// Each command carries the current foreground and background colour. Throughput is
// one byte per clock; the input stalls only while a finished command is not taken.
module ansi_csi_escape_parser_top
  import csi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  csi_in_if.sink    in_ch,
  csi_out_if.source out_ch
);

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;

  // parser state
  parse_mode_t            mode_r, mode_nxt;
  logic                   any_r, any_nxt;
  logic                   in_tok_r, in_tok_nxt;
  logic [1:0]             count_r, count_nxt;
  logic [VALUE_BITS-1:0]  acc_r, acc_nxt;
  logic [VALUE_BITS-1:0]  first_r, first_nxt;
  logic [VALUE_BITS-1:0]  second_r, second_nxt;
  colour_pend_t           pfore_r, pfore_nxt;
  colour_pend_t           pback_r, pback_nxt;
  logic [2:0]             fore_r, fore_nxt;
  logic [2:0]             back_r, back_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  kind_t       kind_r;
  logic [7:0]  pbyte_r;
  logic [15:0] row_r;
  logic [15:0] col_r;
  logic [2:0]  ofore_r;
  logic [2:0]  oback_r;

  // combinational results of one byte
  logic                  emit;
  kind_t                 kind_c;
  logic [7:0]            pbyte_c;
  logic [VALUE_BITS-1:0] row_c;
  logic [VALUE_BITS-1:0] col_c;
  logic                  adv;
  logic                  in_xfer;

  // byte classes
  logic is_digit, is_semi, is_letter;
  logic [VALUE_BITS+3:0] acc_step;
  logic [VALUE_BITS-1:0] acc_sat;

  // token finish
  logic                  fin_on;
  logic [VALUE_BITS-1:0] fin_val;
  logic [VALUE_BITS-1:0] fin_fore_off, fin_back_off;
  logic [1:0]            count_f;
  logic [VALUE_BITS-1:0] first_f, second_f;
  colour_pend_t          pfore_f, pback_f;

  assign is_digit  = (s1_byte_r >= BYTE_ZERO) && (s1_byte_r <= BYTE_NINE);
  assign is_semi   = (s1_byte_r == BYTE_SEMI);
  assign is_letter = ((s1_byte_r >= BYTE_UP_A) && (s1_byte_r <= BYTE_UP_Z)) ||
                     ((s1_byte_r >= BYTE_LO_A) && (s1_byte_r <= BYTE_LO_Z));

  // accumulator times ten plus digit, saturating
  assign acc_step = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) +
                    {{VALUE_BITS{1'b0}}, s1_byte_r[3:0]};
  assign acc_sat  = (acc_step[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? VALUE_MAX
                                                                : acc_step[VALUE_BITS-1:0];

  // a token closes on ';' after digits, or on a final after anything in the body
  assign fin_on  = in_tok_r || (!is_semi && any_r);
  assign fin_val = in_tok_r ? acc_r : '0;
  assign fin_fore_off = fin_val - FORE_LO;
  assign fin_back_off = fin_val - BACK_LO;

  always_comb begin
    count_f  = count_r;
    first_f  = first_r;
    second_f = second_r;
    pfore_f  = pfore_r;
    pback_f  = pback_r;
    if (fin_on) begin
      if (count_r == 2'd0) begin
        first_f = fin_val;
      end
      if (count_r == 2'd1) begin
        second_f = fin_val;
      end
      if (count_r != COUNT_MAX) begin
        count_f = count_r + 2'd1;
      end
      if ((fin_val >= FORE_LO) && (fin_val <= FORE_HI)) begin
        pfore_f = '{pend: 1'b1, idx: fin_fore_off[2:0]};
      end else if ((fin_val >= BACK_LO) && (fin_val <= BACK_HI)) begin
        pback_f = '{pend: 1'b1, idx: fin_back_off[2:0]};
      end
    end
  end

  // parser next state and command
  always_comb begin
    mode_nxt   = mode_r;
    any_nxt    = any_r;
    in_tok_nxt = in_tok_r;
    count_nxt  = count_r;
    acc_nxt    = acc_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    pfore_nxt  = pfore_r;
    pback_nxt  = pback_r;
    fore_nxt   = fore_r;
    back_nxt   = back_r;
    emit       = 1'b0;
    kind_c     = KIND_PRINT;
    pbyte_c    = 8'd0;
    row_c      = '0;
    col_c      = '0;
    case (mode_r)
      MODE_IDLE: begin
        if (s1_byte_r == BYTE_ESC) begin
          mode_nxt = MODE_ESC;
        end else begin
          emit    = 1'b1;
          pbyte_c = s1_byte_r;
        end
      end
      MODE_ESC: begin
        if (s1_byte_r == BYTE_LBRACK) begin
          mode_nxt   = MODE_CSI;
          any_nxt    = 1'b0;
          in_tok_nxt = 1'b0;
          count_nxt  = 2'd0;
          acc_nxt    = '0;
          first_nxt  = '0;
          second_nxt = '0;
          pfore_nxt  = '{pend: 1'b0, idx: 3'd0};
          pback_nxt  = '{pend: 1'b0, idx: 3'd0};
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_CSI: begin
        if (is_digit) begin
          acc_nxt    = in_tok_r ? acc_sat : {{(VALUE_BITS-4){1'b0}}, s1_byte_r[3:0]};
          in_tok_nxt = 1'b1;
          any_nxt    = 1'b1;
        end else begin
          count_nxt  = count_f;
          first_nxt  = first_f;
          second_nxt = second_f;
          pfore_nxt  = pfore_f;
          pback_nxt  = pback_f;
          in_tok_nxt = 1'b0;
          if (is_semi) begin
            any_nxt = 1'b1;
          end else if (!is_letter) begin
            mode_nxt = MODE_SWALLOW;
          end else begin
            mode_nxt = MODE_IDLE;
            case (s1_byte_r)
              BYTE_FIN_J: begin
                if ((count_f != 2'd0) && (first_f == ERASE_ALL)) begin
                  emit   = 1'b1;
                  kind_c = KIND_CLEAR_ALL;
                end else if (count_f == 2'd0) begin
                  emit   = 1'b1;
                  kind_c = KIND_CLEAR_DOWN;
                end
              end
              BYTE_FIN_K: begin
                if (count_f == 2'd0) begin
                  emit   = 1'b1;
                  kind_c = KIND_CLEAR_EOL;
                end
              end
              BYTE_FIN_H: begin
                if (count_f == 2'd0) begin
                  emit   = 1'b1;
                  kind_c = KIND_CURSOR;
                end else if (count_f == COUNT_TWO) begin
                  emit   = 1'b1;
                  kind_c = KIND_CURSOR;
                  row_c  = first_f;
                  col_c  = second_f;
                end
              end
              BYTE_FIN_M: begin
                emit   = 1'b1;
                kind_c = KIND_COLOUR;
                if (count_f == 2'd0) begin
                  fore_nxt = COLOUR_WHITE;
                  back_nxt = COLOUR_BLACK;
                end else begin
                  if (pfore_f.pend) begin
                    fore_nxt = pfore_f.idx;
                  end
                  if (pback_f.pend) begin
                    back_nxt = pback_f.idx;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  // handshake: a byte moves on unless its command meets a full, stalled result register
  assign adv     = s1_valid_r && (!emit || !out_valid_r || out_ch.ready);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;

  assign s1_valid_nxt  = in_xfer ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = (adv && emit) ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_IDLE;
      any_r       <= 1'b0;
      in_tok_r    <= 1'b0;
      count_r     <= 2'd0;
      acc_r       <= '0;
      first_r     <= '0;
      second_r    <= '0;
      pfore_r     <= '{pend: 1'b0, idx: 3'd0};
      pback_r     <= '{pend: 1'b0, idx: 3'd0};
      fore_r      <= COLOUR_WHITE;
      back_r      <= COLOUR_BLACK;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        mode_r   <= mode_nxt;
        any_r    <= any_nxt;
        in_tok_r <= in_tok_nxt;
        count_r  <= count_nxt;
        acc_r    <= acc_nxt;
        first_r  <= first_nxt;
        second_r <= second_nxt;
        pfore_r  <= pfore_nxt;
        pback_r  <= pback_nxt;
        fore_r   <= fore_nxt;
        back_r   <= back_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_ch.in_byte;
    end
    if (adv && emit) begin
      kind_r  <= kind_c;
      pbyte_r <= pbyte_c;
      row_r   <= 16'(row_c);
      col_r   <= 16'(col_c);
      ofore_r <= fore_nxt;
      oback_r <= back_nxt;
    end
  end

  // result channel
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.print_byte = pbyte_r;
  assign out_ch.row        = row_r;
  assign out_ch.column     = col_r;
  assign out_ch.fore_index = ofore_r;
  assign out_ch.back_index = oback_r;

endmodule
